@@ sv/prrts_pkg.sv @@
`timescale 1ns / 1ps
package prrts_pkg;

	// Fixed field widths of the request and result beats
	localparam int unsigned ID_W   = 4;
	localparam int unsigned PRIO_W = 3;
	localparam int unsigned TICK_W = 32;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_SELECT = 2'd2
	} req_type_t;

	typedef enum logic {
		STATUS_OK  = 1'b0,
		STATUS_DUP = 1'b1
	} status_t;

	typedef struct packed {
		req_type_t           req_type;
		logic [ID_W-1:0]     task_id;
		logic [PRIO_W-1:0]   task_priority;
	} req_payload_t;

	typedef struct packed {
		logic [ID_W-1:0]     current_task;
		logic                current_valid;
		logic [ID_W-1:0]     previous_task;
		logic                previous_valid;
		logic                switch_requested;
		logic [TICK_W-1:0]   tick_count;
		status_t             status;
	} rsp_payload_t;

endpackage

@@ sv/prrts_stream_if.sv @@
`timescale 1ns / 1ps
interface prrts_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/priority_round_robin_task_scheduler.sv @@
`timescale 1ns / 1ps
// Priority round-robin ready-list scheduler.
// Channels: req (sink, payload prrts_pkg::req_payload_t) carries add, tick and
// select beats; rsp (source, payload prrts_pkg::rsp_payload_t) returns exactly
// one result beat per request beat; cfg (sink, one bit) writes slicing_enable,
// always ready; the user must write it only while the block is idle, since the
// block does not check it. Ready tasks live in circular doubly linked lists,
// one per level, held in two link memories (next and prev) with a registered
// read and one write port each. Level cursors and counts are small registers.
// Each request beat leaves idle for its own states and ends in a done state.
// A duplicate add, unused code, tick with slicing off or nothing running, or
// empty select goes straight to done. An add writes its links in write
// states W1 and W2. A tick that may rotate checks its level in a check state;
// a select, and a tick that rotates, then read the next link in state R1, and in
// R2 only to skip the sentinel. The result loads into rsp from the done state.
// A new request beat is taken while an earlier result still waits in rsp; if
// rsp stays stalled, the finished result holds the block until it can load.
// Reset clears all ready flags, counts and the running task, points every cursor
// at its own sentinel and sets slicing_enable to 1. Sentinel links read as
// self-linked until written, through per-entry valid bits on the link memories.
module priority_round_robin_task_scheduler #(
	parameter int unsigned NUM_LEVELS = 3,
	parameter int unsigned MAX_TASKS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	prrts_stream_if.sink     req,
	prrts_stream_if.source   rsp,
	prrts_stream_if.sink     cfg
);
	import prrts_pkg::*;

	localparam int unsigned NODE_COUNT = MAX_TASKS + NUM_LEVELS;
	localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
	localparam int unsigned LVL_W      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int unsigned TASK_W     = $clog2(MAX_TASKS);
	localparam int unsigned CNT_W      = $clog2(MAX_TASKS + 1);

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [LVL_W-1:0]  lvl_t;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_ADD_W1   = 7'b0000010,
		ST_ADD_W2   = 7'b0000100,
		ST_TICK_CHK = 7'b0001000,
		ST_SEL_R1   = 7'b0010000,
		ST_SEL_R2   = 7'b0100000,
		ST_DONE     = 7'b1000000
	} state_t;

	// Value an unwritten link entry stands for: sentinels point at themselves
	function automatic node_t node_init(input node_t a);
		node_t r;
		r = (a >= node_t'(MAX_TASKS)) ? a : '0;
		return r;
	endfunction

	state_t                 state_q;
	logic                   slicing_q;
	logic [MAX_TASKS-1:0]   tready_q;
	node_t                  cursor_q [NUM_LEVELS];
	logic [CNT_W-1:0]       count_q  [NUM_LEVELS];
	logic [ID_W-1:0]        running_task_q;
	logic                   running_valid_q;
	logic [TICK_W-1:0]      ticks_q;
	logic [ID_W-1:0]        prev_task_q;
	logic                   prev_valid_q;
	logic                   sw_q;
	status_t                status_q;
	logic [ID_W-1:0]        id_q;
	lvl_t                   lvl_q;
	node_t                  cur_q;
	node_t                  before_q;
	logic                   out_valid_q;
	rsp_payload_t           out_q;

	// Link and level memories
	node_t                  nxt_mem [NODE_COUNT];
	node_t                  prv_mem [NODE_COUNT];
	lvl_t                   lvl_mem [MAX_TASKS];
	logic [NODE_COUNT-1:0]  nxt_ok_q;
	logic [NODE_COUNT-1:0]  prv_ok_q;
	node_t                  nxt_rdata_q, prv_rdata_q;
	node_t                  nxt_raddr_q, prv_raddr_q;
	lvl_t                   lvl_rdata_q;

	node_t                  nxt_raddr, prv_raddr;
	logic                   nxt_we, prv_we;
	node_t                  nxt_waddr, prv_waddr, nxt_wdata, prv_wdata;
	logic                   lvl_we;
	logic [TASK_W-1:0]      lvl_raddr;

	node_t                  nxt_rd, prv_rd;
	logic                   req_fire;
	lvl_t                   add_lvl;
	logic                   add_bad;
	logic                   found;
	lvl_t                   top_lvl;
	node_t                  sent;
	logic                   run_in_range;
	logic                   out_load;

	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign cfg.ready  = 1'b1;
	assign rsp.valid  = out_valid_q;
	assign rsp.payload = out_q;

	// Load the result register once the work is done and the slot is free
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// Clamp the requested priority to the top level
	assign add_lvl = (32'(req.payload.task_priority) >= NUM_LEVELS) ?
		lvl_t'(NUM_LEVELS - 1) : lvl_t'(req.payload.task_priority);
	assign add_bad = (32'(req.payload.task_id) >= MAX_TASKS) ||
		tready_q[TASK_W'(req.payload.task_id)];
	assign run_in_range = 32'(running_task_q) < MAX_TASKS;
	assign sent = node_t'(MAX_TASKS) + node_t'(lvl_q);

	// Resolve link reads: unwritten entries take their reset value
	assign nxt_rd = nxt_ok_q[nxt_raddr_q] ? nxt_rdata_q : node_init(nxt_raddr_q);
	assign prv_rd = prv_ok_q[prv_raddr_q] ? prv_rdata_q : node_init(prv_raddr_q);

	// Highest non-empty level; the last hit wins
	always_comb begin
		found   = 1'b0;
		top_lvl = '0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (count_q[l] != '0) begin
				found   = 1'b1;
				top_lvl = lvl_t'(l);
			end
		end
	end

	// Memory port control
	always_comb begin
		nxt_raddr = (state_q == ST_SEL_R1) ? nxt_rd : cursor_q[top_lvl];
		prv_raddr = cursor_q[add_lvl];
		lvl_raddr = TASK_W'(running_task_q);
		lvl_we    = req_fire && (req.payload.req_type == REQ_ADD) && !add_bad;
		nxt_we    = 1'b0;
		prv_we    = 1'b0;
		nxt_waddr = '0;
		nxt_wdata = '0;
		prv_waddr = '0;
		prv_wdata = '0;
		if (state_q == ST_ADD_W1) begin
			// link the new task between before and cursor
			nxt_we    = 1'b1;
			nxt_waddr = node_t'(id_q);
			nxt_wdata = cur_q;
			prv_we    = 1'b1;
			prv_waddr = node_t'(id_q);
			prv_wdata = prv_rd;
		end else if (state_q == ST_ADD_W2) begin
			nxt_we    = 1'b1;
			nxt_waddr = before_q;
			nxt_wdata = node_t'(id_q);
			prv_we    = 1'b1;
			prv_waddr = cur_q;
			prv_wdata = node_t'(id_q);
		end
	end

	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[nxt_waddr] <= nxt_wdata;
		end
		if (prv_we) begin
			prv_mem[prv_waddr] <= prv_wdata;
		end
		if (lvl_we) begin
			lvl_mem[TASK_W'(req.payload.task_id)] <= add_lvl;
		end
		nxt_rdata_q <= nxt_mem[nxt_raddr];
		prv_rdata_q <= prv_mem[prv_raddr];
		lvl_rdata_q <= lvl_mem[lvl_raddr];
		nxt_raddr_q <= nxt_raddr;
		prv_raddr_q <= prv_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_ok_q <= '0;
			prv_ok_q <= '0;
		end else begin
			if (nxt_we) begin
				nxt_ok_q[nxt_waddr] <= 1'b1;
			end
			if (prv_we) begin
				prv_ok_q[prv_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slicing_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			slicing_q <= cfg.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			tready_q        <= '0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				cursor_q[l] <= node_t'(MAX_TASKS + l);
				count_q[l]  <= '0;
			end
			running_task_q  <= '0;
			running_valid_q <= 1'b0;
			ticks_q         <= '0;
			prev_task_q     <= '0;
			prev_valid_q    <= 1'b0;
			sw_q            <= 1'b0;
			status_q        <= STATUS_OK;
			id_q            <= '0;
			lvl_q           <= '0;
			cur_q           <= '0;
			before_q        <= '0;
			out_valid_q     <= 1'b0;
			out_q           <= '0;
		end else begin
			if (rsp.valid && rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						prev_task_q  <= running_task_q;
						prev_valid_q <= running_valid_q;
						sw_q         <= 1'b0;
						unique case (req.payload.req_type)
							REQ_ADD: begin
								if (add_bad) begin
									status_q <= STATUS_DUP;
									state_q  <= ST_DONE;
								end else begin
									status_q <= STATUS_OK;
									id_q     <= req.payload.task_id;
									lvl_q    <= add_lvl;
									cur_q    <= cursor_q[add_lvl];
									tready_q[TASK_W'(req.payload.task_id)] <= 1'b1;
									count_q[add_lvl] <= count_q[add_lvl] + CNT_W'(1);
									state_q  <= ST_ADD_W1;
								end
							end
							REQ_TICK: begin
								status_q <= STATUS_OK;
								ticks_q  <= ticks_q + TICK_W'(1);
								if (slicing_q && running_valid_q && run_in_range) begin
									state_q <= ST_TICK_CHK;
								end else begin
									state_q <= ST_DONE;
								end
							end
							REQ_SELECT: begin
								status_q <= STATUS_OK;
								if (found) begin
									lvl_q   <= top_lvl;
									state_q <= ST_SEL_R1;
								end else begin
									running_task_q  <= '0;
									running_valid_q <= 1'b0;
									state_q         <= ST_DONE;
								end
							end
							default: begin
								// unused code: change nothing
								status_q <= STATUS_OK;
								state_q  <= ST_DONE;
							end
						endcase
					end
				end
				ST_ADD_W1: begin
					before_q <= prv_rd;
					state_q  <= ST_ADD_W2;
				end
				ST_ADD_W2: begin
					state_q <= ST_DONE;
				end
				ST_TICK_CHK: begin
					// rotate only when the running level holds more than one task
					if (count_q[lvl_rdata_q] > CNT_W'(1)) begin
						sw_q    <= 1'b1;
						lvl_q   <= top_lvl;
						state_q <= ST_SEL_R1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SEL_R1, ST_SEL_R2: begin
					if ((state_q == ST_SEL_R1) && (nxt_rd == sent)) begin
						// skip the sentinel
						state_q <= ST_SEL_R2;
					end else begin
						cursor_q[lvl_q] <= nxt_rd;
						if (nxt_rd < node_t'(MAX_TASKS)) begin
							running_task_q  <= ID_W'(nxt_rd);
							running_valid_q <= 1'b1;
						end else begin
							running_task_q  <= '0;
							running_valid_q <= 1'b0;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q             <= 1'b1;
						out_q.current_task      <= running_valid_q ? running_task_q : '0;
						out_q.current_valid     <= running_valid_q;
						out_q.previous_task     <= prev_valid_q ? prev_task_q : '0;
						out_q.previous_valid    <= prev_valid_q;
						out_q.switch_requested  <= sw_q;
						out_q.tick_count        <= ticks_q;
						out_q.status            <= status_q;
						state_q                 <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A running task is always one that sits in a ready list
	assert property (@(posedge clk) disable iff (!arst_n)
		running_valid_q |-> tready_q[TASK_W'(running_task_q)])
		else $error("running task not marked ready");

	// An accepted tick advances the count by exactly one
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (req.payload.req_type == REQ_TICK)) |=>
		(ticks_q == $past(ticks_q) + TICK_W'(1)))
		else $error("tick count did not advance");

	// A rotation always ends with a task selected
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.payload.switch_requested) |-> rsp.payload.current_valid)
		else $error("switch requested without a current task");

	// A rejected add never comes with a rotation
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.payload.status == STATUS_DUP)) |->
		!rsp.payload.switch_requested)
		else $error("rejected add flagged a switch");

endmodule
